[rtl/core/spi_flash_read_master_core_macros.svh]
// Assertion macros shared by the checker of the SPI flash read master.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef SPI_FLASH_READ_MASTER_CORE_MACROS_SVH
`define SPI_FLASH_READ_MASTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFRM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spi flash read master check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spi flash read master check failed");

`endif

[rtl/core/sfrm_pkg.sv]
package sfrm_pkg;

  // Request type codes of an input beat.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Configuration register indexes (byte address 4*i).
  localparam int  CFG_ADDR_W      = 3;
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_READ_OPCODE = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'h01;
  localparam logic [7:0] READ_OPCODE_RESET = 8'h03;
  localparam logic [7:0] DUMMY_BYTE        = 8'h00;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_START,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SET,
    PH_RISE,
    PH_SAMPLE
  } phase_t;

  typedef struct packed {
    logic        req_type;
    logic [23:0] start_address;
    logic [7:0]  byte_count;
    logic        miso_level;
  } req_beat_t;

  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       master_out;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       done_res;
    logic       busy_res;
  } res_beat_t;

  // Classified command held in the queue.
  typedef struct packed {
    op_t         op;
    logic [23:0] start_address;
    logic [7:0]  byte_count;
    logic        miso_level;
  } cmd_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] read_opcode;
  } cfg_t;

endpackage

[rtl/core/sfrm_front.sv]
module sfrm_front import sfrm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_beat_t req_beat,
  input  logic      pop,
  output q_head_t   head
);

  cmd_t                   q_mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;
  logic                   push;
  cmd_t                   cmd_in;

  always_comb begin
    cmd_in.op            = (req_beat.req_type == REQ_TICK) ? OP_TICK : OP_START;
    cmd_in.start_address = req_beat.start_address;
    cmd_in.byte_count    = req_beat.byte_count;
    cmd_in.miso_level    = req_beat.miso_level;
  end

  assign req_stall = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + QUEUE_CNT_W'(1);
      2'b01:   count_next = count - QUEUE_CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= QUEUE_PTR_W'((32'(wr_ptr) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr <= QUEUE_PTR_W'((32'(rd_ptr) + 1) % QUEUE_DEPTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = q_mem[rd_ptr];

endmodule

[rtl/core/sfrm_back.sv]
module sfrm_back import sfrm_pkg::*; #(
  parameter int ADDR_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  q_head_t   head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res_beat
);

  localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
  localparam int ADDR_PAD   = ADDR_BYTES * 8;
  localparam logic [2:0] LAST_ADDR_PHASE = 3'(ADDR_BYTES);
  localparam logic [ADDR_PAD-1:0] ADDR_MASK = ADDR_PAD'((64'd1 << ADDR_BITS) - 64'd1);

  phase_t              phase, phase_next;
  logic [2:0]          bit_index, bit_index_next;
  logic [2:0]          byte_phase, byte_phase_next;
  logic [7:0]          bytes_left, bytes_left_next;
  logic [ADDR_PAD-1:0] address_hold, address_hold_next;
  logic [7:0]          tx_shift, tx_shift_next;
  logic [7:0]          rx_shift, rx_shift_next;
  logic [7:0]          tick_count, tick_count_next;
  logic                cs_n, cs_n_next;
  logic                sclk, sclk_next;
  logic                mosi, mosi_next;
  res_beat_t           res_beat_next;

  logic       is_start;
  logic       is_tick;
  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic       phase_end;
  logic       byte_end;
  logic       in_addr;
  logic [2:0] byte_phase_inc;
  logic       finish;
  logic [7:0] rx_shifted;

  assign pop = head.valid && (!res_valid || !res_stall);

  always_comb begin
    is_start       = (head.cmd.op == OP_START);
    is_tick        = (head.cmd.op == OP_TICK);
    limit          = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
    tick_inc       = tick_count + 8'd1;
    phase_end      = (tick_inc >= limit);
    byte_end       = (bit_index == 3'd0);
    in_addr        = (byte_phase <= LAST_ADDR_PHASE);
    byte_phase_inc = byte_phase + 3'd1;
    rx_shifted     = {rx_shift[6:0], head.cmd.miso_level};
    // The address bytes end the command; with no data bytes requested the
    // transaction closes there, otherwise it closes after the final data byte.
    if (in_addr) begin
      finish = (byte_phase_inc > LAST_ADDR_PHASE) && (bytes_left == 8'd0);
    end else begin
      finish = (bytes_left <= 8'd1);
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (pop) begin
      unique case (phase)
        PH_IDLE: begin
          if (is_start) phase_next = PH_SET;
        end
        PH_SET: begin
          if (is_tick && phase_end) phase_next = PH_RISE;
        end
        PH_RISE: begin
          if (is_tick && phase_end) phase_next = PH_SAMPLE;
        end
        PH_SAMPLE: begin
          if (is_tick && phase_end) begin
            if (byte_end && finish) phase_next = PH_IDLE;
            else phase_next = PH_SET;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Datapath and result beat.
  always_comb begin
    bit_index_next    = bit_index;
    byte_phase_next   = byte_phase;
    bytes_left_next   = bytes_left;
    address_hold_next = address_hold;
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    tick_count_next   = tick_count;
    cs_n_next         = cs_n;
    sclk_next         = sclk;
    mosi_next         = mosi;
    res_beat_next     = '0;

    if (phase == PH_IDLE) begin
      if (is_start) begin
        address_hold_next = ADDR_PAD'(head.cmd.start_address) & ADDR_MASK;
        bytes_left_next   = head.cmd.byte_count;
        byte_phase_next   = 3'd0;
        bit_index_next    = 3'd7;
        tx_shift_next     = cfg.read_opcode;
        rx_shift_next     = 8'd0;
        tick_count_next   = 8'd0;
        cs_n_next         = 1'b0;
        sclk_next         = 1'b0;
      end
    end else if (is_tick) begin
      tick_count_next = phase_end ? 8'd0 : tick_inc;
      if (phase_end) begin
        unique case (phase)
          PH_SET: begin
            mosi_next = tx_shift[bit_index];
          end
          PH_RISE: begin
            sclk_next = 1'b1;
          end
          default: begin
            sclk_next     = 1'b0;
            rx_shift_next = rx_shifted;
            if (!byte_end) begin
              bit_index_next = bit_index - 3'd1;
            end else begin
              bit_index_next = 3'd7;
              rx_shift_next  = 8'd0;
              if (in_addr) begin
                byte_phase_next = byte_phase_inc;
                if (byte_phase_inc <= LAST_ADDR_PHASE) begin
                  // Address bytes leave the top of the hold register in turn.
                  tx_shift_next     = address_hold[ADDR_PAD-1 -: 8];
                  address_hold_next = address_hold << 8;
                end else if (bytes_left != 8'd0) begin
                  tx_shift_next = DUMMY_BYTE;
                end
              end else begin
                res_beat_next.rx_valid = 1'b1;
                res_beat_next.rx_byte  = rx_shifted;
                res_beat_next.rx_last  = (bytes_left <= 8'd1);
                if (bytes_left != 8'd0) bytes_left_next = bytes_left - 8'd1;
                tx_shift_next = DUMMY_BYTE;
              end
              if (finish) begin
                cs_n_next              = 1'b1;
                res_beat_next.done_res = 1'b1;
              end
            end
          end
        endcase
      end
    end

    res_beat_next.chip_select_n = cs_n_next;
    res_beat_next.serial_clock  = sclk_next;
    res_beat_next.master_out    = mosi_next;
    res_beat_next.busy_res      = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_index    <= 3'd7;
      byte_phase   <= 3'd0;
      bytes_left   <= 8'd0;
      address_hold <= '0;
      tx_shift     <= 8'd0;
      rx_shift     <= 8'd0;
      tick_count   <= 8'd0;
      cs_n         <= 1'b1;
      sclk         <= 1'b0;
      mosi         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        bit_index    <= bit_index_next;
        byte_phase   <= byte_phase_next;
        bytes_left   <= bytes_left_next;
        address_hold <= address_hold_next;
        tx_shift     <= tx_shift_next;
        rx_shift     <= rx_shift_next;
        tick_count   <= tick_count_next;
        cs_n         <= cs_n_next;
        sclk         <= sclk_next;
        mosi         <= mosi_next;
      end
      if (pop) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_beat <= res_beat_next;
    end
  end

endmodule

[rtl/core/spi_flash_read_master_core.sv]
// Channel   Beat type    Handshake                 Direction
// req       req_beat_t   req_valid / req_stall     into the core
// res       res_beat_t   res_valid / res_stall     out of the core
// cfg       APB write    psel/penable/pwrite       into the core
//
// The core accepts one request beat per clock while req_stall is low and
// returns one result beat for each, through the queue and the result
// register; the back engine steps once for each beat that it pops.
// Reset is synchronous and active high; it needs no clearing pass.
// A two-entry queue parts the front from the back, so a stalled result
// holds the engine while the front still takes beats until the queue fills.

// SPI mode-0 master that reads serial NOR flash with a single read command.
// The front classifies each request beat as a start or a tick and queues it.
// The back runs the bit engine: every bit goes through a set phase (drive
// MOSI), a rise phase (raise SCLK) and a sample phase (sample MISO, lower
// SCLK), each lasting phase_ticks tick beats. A start beat is taken only
// while idle; the opcode, the address bytes and then byte_count dummy bytes
// are shifted out MSB first. Each received data byte is reported in its
// result beat, and the final one also raises chip select and pulses done.
module spi_flash_read_master_core import sfrm_pkg::*; #(
  parameter int ADDR_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_beat_t             req_beat,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_beat_t             res_beat,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  q_head_t head;
  logic    pop;
  logic    cfg_write;
  logic    reg_index;

  // Registers sit at byte addresses 0 and 4; bit 2 picks the register.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks <= PHASE_TICKS_RESET;
      cfg.read_opcode <= READ_OPCODE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_PHASE_TICKS: cfg.phase_ticks <= pwdata[7:0];
        REG_READ_OPCODE: cfg.read_opcode <= pwdata[7:0];
        default:         cfg.phase_ticks <= cfg.phase_ticks;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PHASE_TICKS: prdata = {24'd0, cfg.phase_ticks};
      REG_READ_OPCODE: prdata = {24'd0, cfg.read_opcode};
      default:         prdata = 32'd0;
    endcase
  end

  // Front: classify request beats and queue them.
  sfrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_beat  (req_beat),
    .pop       (pop),
    .head      (head)
  );

  // Back: bit engine with the result register.
  sfrm_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat)
  );

endmodule

[rtl/core/sfrm_checker.sv]
`include "spi_flash_read_master_core_macros.svh"

module sfrm_checker import sfrm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_stall,
  input res_beat_t res_beat
);

  // A stalled result beat stays and holds its payload.
  `SFRM_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_beat))

  // Done means chip select is back high and the engine is idle.
  `SFRM_ASSERT_SAME(a_done_idle, res_valid && res_beat.done_res, res_beat.chip_select_n && !res_beat.busy_res)

  // The final data byte closes the transaction in the same beat.
  `SFRM_ASSERT_SAME(a_last_done, res_valid && res_beat.rx_valid && res_beat.rx_last, res_beat.done_res)

  // Chip select is low exactly while a transaction is in progress.
  `SFRM_ASSERT_SAME(a_busy_cs, res_valid, res_beat.busy_res != res_beat.chip_select_n)

endmodule

bind spi_flash_read_master_core sfrm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_beat  (res_beat)
);

[test/tb_spi_flash_read_master_core.sv]
module tb_spi_flash_read_master_core;
  import sfrm_pkg::*;

  // The core is built with its default address width, so three address bytes
  // follow the opcode.
  localparam int ADDR_BYTES = 3;

  // Tracks the SPI pin levels and the received bytes that each accepted
  // request beat should produce, and compares them with the result beats.
  class pin_level_tracker;
    logic [7:0]  ticks_per_phase;
    logic [7:0]  opcode;
    phase_t      phase;
    logic [2:0]  bit_pos;
    logic [2:0]  stage;
    logic [7:0]  bytes_to_go;
    logic [23:0] flash_addr;
    logic [7:0]  tx_bits;
    logic [7:0]  rx_bits;
    logic [7:0]  tick_cnt;
    logic        cs_n;
    logic        sclk;
    logic        mosi;
    res_beat_t   pins_due[$];
    int unsigned errors;

    function new();
      ticks_per_phase = PHASE_TICKS_RESET;
      opcode = READ_OPCODE_RESET;
      phase = PH_IDLE;
      bit_pos = 3'd7;
      stage = 3'd0;
      bytes_to_go = 8'h00;
      flash_addr = 24'h000000;
      tx_bits = 8'h00;
      rx_bits = 8'h00;
      tick_cnt = 8'h00;
      cs_n = 1'b1;
      sclk = 1'b0;
      mosi = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == REG_PHASE_TICKS) begin
        ticks_per_phase = value;
      end else if (idx == REG_READ_OPCODE) begin
        opcode = value;
      end
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return pins_due.size();
    endfunction

    // Advances the engine by one request beat and queues the pin levels
    // that the core must report for it.
    function void take_request(req_beat_t b);
      res_beat_t  r;
      logic [7:0] limit;
      logic       finish;
      r = '0;
      finish = 1'b0;
      if (b.req_type == REQ_START) begin
        if (phase == PH_IDLE) begin
          flash_addr = b.start_address;
          bytes_to_go = b.byte_count;
          stage = 3'd0;
          bit_pos = 3'd7;
          tx_bits = opcode;
          rx_bits = 8'h00;
          tick_cnt = 8'h00;
          cs_n = 1'b0;
          sclk = 1'b0;
          phase = PH_SET;
        end
      end else if (phase != PH_IDLE) begin
        limit = (ticks_per_phase == 8'h00) ? 8'h01 : ticks_per_phase;
        tick_cnt = tick_cnt + 8'h01;
        if (tick_cnt >= limit) begin
          tick_cnt = 8'h00;
          case (phase)
            PH_SET: begin
              mosi = tx_bits[bit_pos];
              phase = PH_RISE;
            end
            PH_RISE: begin
              sclk = 1'b1;
              phase = PH_SAMPLE;
            end
            default: begin
              rx_bits = {rx_bits[6:0], b.miso_level};
              sclk = 1'b0;
              if (bit_pos != 3'd0) begin
                bit_pos = bit_pos - 3'd1;
                phase = PH_SET;
              end else begin
                bit_pos = 3'd7;
                if (stage <= ADDR_BYTES) begin
                  stage = stage + 3'd1;
                  if (stage <= ADDR_BYTES) begin
                    tx_bits = 8'(flash_addr >> (8 * (ADDR_BYTES - int'(stage))));
                  end else if (bytes_to_go == 8'h00) begin
                    finish = 1'b1;
                  end else begin
                    tx_bits = DUMMY_BYTE;
                  end
                end else begin
                  r.rx_valid = 1'b1;
                  r.rx_byte = rx_bits;
                  r.rx_last = (bytes_to_go <= 8'h01);
                  if (bytes_to_go != 8'h00) begin
                    bytes_to_go = bytes_to_go - 8'h01;
                  end
                  tx_bits = DUMMY_BYTE;
                  if (bytes_to_go == 8'h00) begin
                    finish = 1'b1;
                  end
                end
                rx_bits = 8'h00;
                if (finish) begin
                  cs_n = 1'b1;
                  r.done_res = 1'b1;
                  phase = PH_IDLE;
                end else begin
                  phase = PH_SET;
                end
              end
            end
          endcase
        end
      end
      r.chip_select_n = cs_n;
      r.serial_clock = sclk;
      r.master_out = mosi;
      r.busy_res = (phase != PH_IDLE);
      pins_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_beat_t got);
      res_beat_t want;
      if (pins_due.size() == 0) begin
        $display("%0t: result beat expected none got %h", $time, got);
        errors++;
        return;
      end
      want = pins_due.pop_front();
      compare_field("chip_select_n", 8'(want.chip_select_n), 8'(got.chip_select_n));
      compare_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
      compare_field("master_out", 8'(want.master_out), 8'(got.master_out));
      compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("rx_last", 8'(want.rx_last), 8'(got.rx_last));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_beat_t             req_beat = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_beat_t             res_beat;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = 32'h0;
  logic [31:0]           prdata;
  logic                  pready;

  pin_level_tracker tracker;

  // When set, the matching side runs without any idle or stall cycles for
  // the whole phase.
  bit calm_in = 1'b1;
  bit calm_out = 1'b1;

  spi_flash_read_master_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_beat (req_beat),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_beat (res_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Length of an idle or stall stretch: mostly from the shortest of three
  // ranges, now and then a long one so the queue inside the core fills up.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(6, 4);
    return $urandom_range(48, 12);
  endfunction

  // Byte counts stay small so that many transactions complete; long reads
  // only show up when a phase is one tick, where they stay affordable.
  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 45) return 8'($urandom_range(2, 0));
    if (r < 85) return 8'($urandom_range(6, 3));
    if (r < 97 || tracker.ticks_per_phase > 8'h01) return 8'($urandom_range(24, 7));
    return 8'($urandom_range(255, 25));
  endfunction

  // The receiver side: the stall line is changed on the falling edge only,
  // alternating free stretches with stall stretches of random length.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_stall = 1'b1;
        hold_left--;
      end else begin
        res_stall = 1'b0;
        if (!calm_out && $urandom_range(5, 0) == 0) begin
          hold_left = pause_len();
        end
      end
    end
  end

  // Every result beat taken at a rising edge is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      tracker.check_result(res_beat);
    end
  end

  // Drives one request beat, with an optional idle gap in front of it, and
  // hands it to the tracker at the edge where the core takes it. Valid does
  // not look at stall, and the payload holds while the beat waits.
  task automatic send_beat(input req_beat_t b);
    int unsigned gap;
    gap = (!calm_in && $urandom_range(3, 0) == 0) ? pause_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_beat = b;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    tracker.take_request(b);
  endtask

  // Tick beats carry random address and count bits, which the core must
  // ignore.
  task automatic send_tick(input logic miso);
    req_beat_t b;
    b.req_type = REQ_TICK;
    b.start_address = 24'($urandom);
    b.byte_count = 8'($urandom);
    b.miso_level = miso;
    send_beat(b);
  endtask

  task automatic send_start(input logic [23:0] addr, input logic [7:0] count);
    req_beat_t b;
    b.req_type = REQ_START;
    b.start_address = addr;
    b.byte_count = count;
    b.miso_level = 1'($urandom);
    send_beat(b);
  endtask

  // Lowers valid and waits until every expected result has come back, then
  // gives the two-stage pipeline time to go quiet.
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [7:0] value,
                            output logic [31:0] rd);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = CFG_ADDR_W'({idx, 2'b00});
    pwdata = {24'h000000, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Writes a register, updates the tracker and reads the value back.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    tracker.set_reg(idx, value);
    apb_access(1'b0, idx, 8'h00, rd);
    if (rd[7:0] !== value) begin
      $display("%0t: register %0d read expected %0h got %0h", $time, idx, value, rd[7:0]);
      tracker.errors++;
    end
  endtask

  // Starts a new phase of the run with fresh settings. The core is drained
  // first; an SPI transfer may still be open and simply carries on at the new
  // rate or with the new opcode in place for the next start.
  task automatic configure(input logic [7:0] ticks, input logic [7:0] op);
    drain();
    write_reg(REG_PHASE_TICKS, ticks);
    write_reg(REG_READ_OPCODE, op);
    calm_in = ($urandom_range(3, 0) == 0);
    calm_out = ($urandom_range(3, 0) == 0);
  endtask

  // Random traffic shaped like real use: a start whenever the engine is idle,
  // then ticks with random MISO levels until the transfer ends. Stray ticks
  // while idle and starts while busy are thrown in as noise and do not count
  // toward the budget, since the core ignores them.
  task automatic run_phase(input int unsigned budget, input bit long_first);
    int unsigned sent;
    bit          need_long;
    sent = 0;
    need_long = long_first;
    while (sent < budget) begin
      if (!tracker.busy()) begin
        if ($urandom_range(99, 0) < 8) begin
          send_tick(1'($urandom));
        end else begin
          send_start(24'($urandom), need_long ? 8'hFF : pick_count());
          need_long = 1'b0;
          sent++;
        end
      end else if ($urandom_range(99, 0) == 0) begin
        send_start(24'($urandom), 8'($urandom));
      end else begin
        send_tick(1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned n;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, at the reset settings. A tick while idle must leave the
    // pins alone.
    send_tick(1'b1);

    // Highest address with no data bytes: the transfer ends right after the
    // last address bit. A start arriving mid-transfer must be ignored.
    send_start(24'hFFFFFF, 8'h00);
    n = 0;
    while (tracker.busy()) begin
      if (n == 10) begin
        send_start(24'h000000, 8'hFF);
      end
      send_tick(n[0]);
      n++;
    end

    // Lowest address with one data byte read as all ones.
    send_start(24'h000000, 8'h01);
    while (tracker.busy()) send_tick(1'b1);

    // Two data bytes with random MISO, so the last mark moves.
    send_start(24'h5A5A5A, 8'h02);
    while (tracker.busy()) send_tick(1'($urandom));

    // A zero phase length behaves as one tick.
    configure(8'h00, 8'hFF);
    run_phase(160, 1'b0);

    configure(8'h02, 8'h00);
    run_phase(110, 1'b0);

    // The slowest clock only gets part way into a transfer, which then
    // finishes under the next settings.
    configure(8'hFF, 8'hA5);
    run_phase(60, 1'b0);

    configure(8'h01, 8'($urandom));
    run_phase(90, 1'b0);

    configure(8'h03, 8'($urandom));
    run_phase(70, 1'b0);

    drain();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake; the longest correct run is far shorter.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
